@@ rtl/core/plwc_pkg.sv @@
package plwc_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ROOT_W    = 25;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int ACC_W     = 64;
    localparam int TOTAL_W   = 40;
    localparam int DIV_STEPS = ACC_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef logic [1:0] mul_sel_t;

    localparam mul_sel_t MUL_DX = 2'd0;
    localparam mul_sel_t MUL_DY = 2'd1;
    localparam mul_sel_t MUL_SX = 2'd2;
    localparam mul_sel_t MUL_SY = 2'd3;

    typedef struct packed {
        logic     accept;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sq_hold;
        logic     root_start;
        logic     root_step;
        logic     acc_x;
        logic     acc_y;
        logic     div_start;
        logic     div_step;
        logic     out_load;
    } plwc_cmd_t;

    typedef struct packed {
        logic first_vertex;
        logic total_zero;
    } plwc_status_t;

endpackage

@@ rtl/core/plwc_ctrl.sv @@
module plwc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  plwc_pkg::plwc_status_t status,
    output plwc_pkg::plwc_cmd_t    cmd
);
    import plwc_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL_DX = 4'd1;
    localparam logic [3:0] ST_MUL_DY = 4'd2;
    localparam logic [3:0] ST_SQ_SUM = 4'd3;
    localparam logic [3:0] ST_ROOT   = 4'd4;
    localparam logic [3:0] ST_MUL_SX = 4'd5;
    localparam logic [3:0] ST_MUL_SY = 4'd6;
    localparam logic [3:0] ST_ACC_Y  = 4'd7;
    localparam logic [3:0] ST_CHK    = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_FIN    = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = s_tlast;
                    if (status.first_vertex)
                        state_next = s_tlast ? ST_FIN : ST_IDLE;
                    else
                        state_next = ST_MUL_DX;
                end
            end
            ST_MUL_DX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                state_next  = ST_MUL_DY;
            end
            ST_MUL_DY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DY;
                cmd.sq_hold = 1'b1;
                state_next  = ST_SQ_SUM;
            end
            ST_SQ_SUM:
            begin
                cmd.root_start = 1'b1;
                cnt_next       = STEP_W'(ROOT_W - 1);
                state_next     = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MUL_SX;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_MUL_SX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SX;
                state_next  = ST_MUL_SY;
            end
            ST_MUL_SY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SY;
                cmd.acc_x   = 1'b1;
                state_next  = ST_ACC_Y;
            end
            ST_ACC_Y:
            begin
                cmd.acc_y  = 1'b1;
                state_next = last_reg ? ST_CHK : ST_IDLE;
            end
            ST_CHK:
            begin
                if (status.total_zero)
                    state_next = ST_FIN;
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = STEP_W'(DIV_STEPS - 1);
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_FIN:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending beat");

    a_root_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> (cnt_reg <= STEP_W'(ROOT_W - 1)))
        else $error("root step count out of range");

    a_single_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && s_tvalid && s_tlast && status.first_vertex)
        |=> (state_reg == ST_FIN))
        else $error("single vertex polyline did not go to finish");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.total_zero)
        else $error("division started with zero length");
`endif

endmodule

@@ rtl/core/plwc_datapath.sv @@
module plwc_datapath #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  plwc_pkg::plwc_cmd_t                   cmd,
    input  logic signed [plwc_pkg::COORD_W-1:0]   in_x,
    input  logic signed [plwc_pkg::COORD_W-1:0]   in_y,
    output plwc_pkg::plwc_status_t                status,
    output logic signed [plwc_pkg::COORD_W-1:0]   out_x,
    output logic signed [plwc_pkg::COORD_W-1:0]   out_y,
    output logic                                  out_flag
);
    import plwc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int MUL_W  = DIFF_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int TRY_W  = REM_W + 2;
    localparam int DEN_W  = TOTAL_W + 1;

    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, sx_reg, sy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [SQ_W-1:0]           sq_reg, rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic signed [ACC_W-1:0]   wsum_reg [2];
    logic [TOTAL_W-1:0]        total_reg;
    logic [DEN_W-1:0]          den_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                      out_flag_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [TRY_W-1:0]          root_try, root_cand;
    logic                      root_ge;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [TOTAL_W:0]          total_sum;
    logic [ACC_W-1:0]          quo [2];
    logic                      neg [2];

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] p
    );
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {p[ACC_W-1], p};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s[ACC_W-1:0];
    endfunction

    // quotient magnitude to signed coordinate, clamped to the coordinate range
    function automatic logic [COORD_W-1:0] coord_result(
        input logic [ACC_W-1:0] q,
        input logic             n
    );
        logic [COORD_W-1:0] lo;
        lo = q[COORD_W-1:0];
        if (q[ACC_W-1:COORD_W-1] != '0)
            return n ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        return n ? (~lo + 1'b1) : lo;
    endfunction

    assign status.first_vertex = (cnt_reg == '0);
    assign status.total_zero   = (total_reg == '0);
    assign out_x    = out_x_reg;
    assign out_y    = out_y_reg;
    assign out_flag = out_flag_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = {dx_reg[DIFF_W-1], dx_reg};
                mul_b = {dx_reg[DIFF_W-1], dx_reg};
            end
            MUL_DY:
            begin
                mul_a = {dy_reg[DIFF_W-1], dy_reg};
                mul_b = {dy_reg[DIFF_W-1], dy_reg};
            end
            MUL_SX:
            begin
                mul_a = {sx_reg[DIFF_W-1], sx_reg};
                mul_b = signed'({{(MUL_W-ROOT_W){1'b0}}, root_reg});
            end
            default:
            begin
                mul_a = {sy_reg[DIFF_W-1], sy_reg};
                mul_b = signed'({{(MUL_W-ROOT_W){1'b0}}, root_reg});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one result bit per step: try (4*root + 1) against the shifted remainder
    assign root_try  = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign root_cand = {{(TRY_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
    assign root_ge   = (root_try >= root_cand);

    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign total_sum = {1'b0, total_reg} + {{(TOTAL_W+1-ROOT_W){1'b0}}, root_reg};

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [ACC_W-1:0] num_reg, quo_reg, mag;
        logic [DEN_W-1:0] drem_reg;
        logic             neg_reg;
        logic [DEN_W:0]   try_v;
        logic             ge;

        assign mag   = wsum_reg[l][ACC_W-1] ? (~wsum_reg[l] + 1'b1) : wsum_reg[l];
        assign try_v = {drem_reg, num_reg[ACC_W-1]};
        assign ge    = (try_v >= {1'b0, den_reg});

        always_ff @(posedge clk)
        begin
            if (cmd.div_start)
            begin
                neg_reg  <= wsum_reg[l][ACC_W-1];
                // rounding: add half the divisor before dividing
                num_reg  <= mag + {{(ACC_W-TOTAL_W){1'b0}}, total_reg};
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                num_reg  <= num_reg << 1;
                drem_reg <= ge ? DEN_W'(try_v - {1'b0, den_reg}) : try_v[DEN_W-1:0];
                quo_reg  <= {quo_reg[ACC_W-2:0], ge};
            end
        end

        assign quo[l] = quo_reg;
        assign neg[l] = neg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            prev_x_reg <= in_x;
            prev_y_reg <= in_y;
            dx_reg     <= {in_x[COORD_W-1], in_x} - {prev_x_reg[COORD_W-1], prev_x_reg};
            dy_reg     <= {in_y[COORD_W-1], in_y} - {prev_y_reg[COORD_W-1], prev_y_reg};
            sx_reg     <= {in_x[COORD_W-1], in_x} + {prev_x_reg[COORD_W-1], prev_x_reg};
            sy_reg     <= {in_y[COORD_W-1], in_y} + {prev_y_reg[COORD_W-1], prev_y_reg};
            if (cnt_reg == '0)
            begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
            end
        end
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.sq_hold)
            sq_reg <= prod_reg[SQ_W-1:0];
        if (cmd.root_start)
        begin
            rad_reg  <= sq_reg + prod_reg[SQ_W-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= root_ge ? REM_W'(root_try - root_cand) : root_try[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], root_ge};
        end
        if (cmd.div_start)
            den_reg <= {total_reg, 1'b0};
        if (cmd.out_load)
        begin
            if (total_reg == '0)
            begin
                out_x_reg    <= first_x_reg;
                out_y_reg    <= first_y_reg;
                out_flag_reg <= 1'b1;
            end
            else
            begin
                out_x_reg    <= coord_result(quo[0], neg[0]);
                out_y_reg    <= coord_result(quo[1], neg[1]);
                out_flag_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            wsum_reg[0] <= '0;
            wsum_reg[1] <= '0;
            total_reg   <= '0;
        end
        else if (cmd.out_load)
        begin
            cnt_reg     <= '0;
            wsum_reg[0] <= '0;
            wsum_reg[1] <= '0;
            total_reg   <= '0;
        end
        else
        begin
            if (cmd.accept && cnt_reg != CNT_W'(MAX_POINTS))
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.acc_x)
            begin
                wsum_reg[0] <= sat_add(wsum_reg[0], prod_ext);
                total_reg   <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            end
            if (cmd.acc_y)
                wsum_reg[1] <= sat_add(wsum_reg[1], prod_ext);
        end
    end

endmodule

@@ rtl/core/polyline_length_weighted_centroid_unit.sv @@
// A vertex after the first holds s_axis_tready low through accept, squares, their sum,
// 25 square root steps, products and sums; a first vertex that is not last is only
// accepted. Output valid follows the last vertex after a check state and 64 divide
// steps; the divide is skipped with no length, and a lone vertex goes straight to the
// final state, where a result still waiting in the output register holds the next.
// Reset (rst_n, async, active low) clears the controller, the vertex count and the sums.
module polyline_length_weighted_centroid_unit #(
    parameter int MAX_POINTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // point_x[23:0], point_y[47:24]
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // center_x[23:0], center_y[47:24]
    output logic        m_axis_tuser    // fell_back_first
);
    import plwc_pkg::*;

    plwc_cmd_t                 cmd;
    plwc_status_t              status;
    logic signed [COORD_W-1:0] cx, cy;

    plwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tlast  (s_axis_tlast),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plwc_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_x     (s_axis_tdata[COORD_W-1:0]),
        .in_y     (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .status   (status),
        .out_x    (cx),
        .out_y    (cy),
        .out_flag (m_axis_tuser)
    );

    assign m_axis_tdata = {cy, cx};

endmodule

@@ verif/polyline_length_weighted_centroid_unit_tb.sv @@
`timescale 1ns / 1ps

module polyline_length_weighted_centroid_unit_tb;
    import plwc_pkg::COORD_W;
    import plwc_pkg::ACC_W;
    import plwc_pkg::TOTAL_W;

    // small vertex limit keeps the saturation test short
    localparam int MAX_POINTS   = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 128;
    localparam int REPORT_LINES = 200;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0] wsum_t;
    typedef logic [TOTAL_W-1:0] total_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam wsum_t WSUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam wsum_t WSUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam total_t TOTAL_MAX = '1;

    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        logic   fell_back_first;
    } centroid_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    // running polyline state of the predictor
    coord_t      prev_x, prev_y, first_x, first_y;
    wsum_t       wsum_x, wsum_y;
    total_t      length_total;
    int unsigned vertex_count;

    // predicted results, written at log_wr and consumed at log_rd
    centroid_t   centroid_log [int];
    int          log_wr;
    int          log_rd;
    centroid_t   want_centroid;
    int          mismatches;
    int          sent_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycle_count;

    polyline_length_weighted_centroid_unit #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what);
        begin
            mismatches++;
            if (mismatches <= REPORT_LINES)
                $display("[%0t] centroid error: %s", $time, what);
        end
    endtask

    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rem;
        root  = '0;
        probe = 64'd1 << 62;
        rem   = n;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic wsum_t clip_add(input wsum_t acc, input wsum_t term);
        wsum_t sum;
        sum = acc + term;
        if (term > 0 && sum < acc)
            return WSUM_MAX;
        if (term < 0 && sum > acc)
            return WSUM_MIN;
        return sum;
    endfunction

    // weighted sum carries twice the midpoint, so divide by twice the total,
    // rounding half away from zero
    function automatic coord_t mean_coord(input wsum_t sum, input total_t total);
        logic [64:0] mag;
        logic [64:0] quot;
        longint      signed_q;
        mag = {1'b0, sum};
        if (sum < 0)
            mag = {1'b1, 64'd0} - {1'b0, sum};
        quot = (mag + {25'd0, total}) / {24'd0, total, 1'b0};
        if (quot > 65'h80_0000)
            quot = 65'h80_0000;
        signed_q = (sum < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
        if (signed_q > longint'(COORD_MAX))
            signed_q = longint'(COORD_MAX);
        if (signed_q < longint'(COORD_MIN))
            signed_q = longint'(COORD_MIN);
        return coord_t'(signed_q);
    endfunction

    task automatic clear_polyline();
        begin
            prev_x       = '0;
            prev_y       = '0;
            first_x      = '0;
            first_y      = '0;
            wsum_x       = '0;
            wsum_y       = '0;
            length_total = '0;
            vertex_count = 0;
        end
    endtask

    task automatic track_vertex(input coord_t x, input coord_t y, input logic is_last);
        longint      dx, dy;
        logic [63:0] seg_len;
        logic [63:0] total_wide;
        centroid_t   result;
        begin
            if (vertex_count == 0)
            begin
                first_x = x;
                first_y = y;
            end
            else
            begin
                dx      = longint'(x) - longint'(prev_x);
                dy      = longint'(y) - longint'(prev_y);
                seg_len = floor_root(64'(dx * dx + dy * dy));
                wsum_x  = clip_add(wsum_x, (longint'(x) + longint'(prev_x)) * longint'(seg_len));
                wsum_y  = clip_add(wsum_y, (longint'(y) + longint'(prev_y)) * longint'(seg_len));
                total_wide = {24'd0, length_total} + seg_len;
                length_total = (total_wide > {24'd0, TOTAL_MAX}) ? TOTAL_MAX
                                                                : total_wide[TOTAL_W-1:0];
            end
            prev_x = x;
            prev_y = y;
            if (vertex_count < MAX_POINTS)
                vertex_count++;
            if (is_last)
            begin
                if (length_total == 0)
                begin
                    result.center_x        = first_x;
                    result.center_y        = first_y;
                    result.fell_back_first = 1'b1;
                end
                else
                begin
                    result.center_x        = mean_coord(wsum_x, length_total);
                    result.center_y        = mean_coord(wsum_y, length_total);
                    result.fell_back_first = 1'b0;
                end
                centroid_log[log_wr] = result;
                log_wr++;
                clear_polyline();
            end
        end
    endtask

    // entered and left at a falling edge; tvalid stays up for a back-to-back beat
    task automatic send_vertex(input coord_t x, input coord_t y, input logic is_last);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {y, x};
            s_axis_tlast  <= is_last;
            do
                @(posedge clk);
            while (!s_axis_tready);
            track_vertex(x, y, is_last);
            sent_count++;
            @(negedge clk);
        end
    endtask

    task automatic send_random_polyline();
        int     n, shape, k;
        coord_t x, y;
        begin
            shape = $urandom_range(0, 9);
            n = (shape == 0) ? 1 : $urandom_range(2, 10);
            x = coord_t'($urandom);
            y = coord_t'($urandom);
            for (k = 0; k < n; k++)
            begin
                // shape 1 repeats one vertex throughout: no length at all
                if (k > 0 && shape != 1)
                begin
                    case ($urandom_range(0, 7))
                        0, 1:
                        begin
                            x = coord_t'($urandom);
                            y = coord_t'($urandom);
                        end
                        2, 3:
                        begin
                            x = coord_t'(int'(x) + int'($urandom_range(0, 511)) - 256);
                            y = coord_t'(int'(y) + int'($urandom_range(0, 511)) - 256);
                        end
                        4:
                        begin
                            x = coord_t'(int'(x) + int'($urandom_range(0, 2)) - 1);
                            y = coord_t'(int'(y) + int'($urandom_range(0, 2)) - 1);
                        end
                        5:
                        begin
                            x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                            y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                        end
                        default: ;  // zero-length segment
                    endcase
                end
                send_vertex(x, y, k == n - 1);
            end
        end
    endtask

    task automatic test_single_vertex();
        begin
            send_vertex(COORD_MAX, COORD_MIN, 1'b1);
            send_vertex(COORD_MIN, COORD_MAX, 1'b1);
            send_vertex('0, coord_t'(-1), 1'b1);
        end
    endtask

    task automatic test_no_length();
        begin
            send_vertex(COORD_MIN, COORD_MAX, 1'b0);
            send_vertex(COORD_MIN, COORD_MAX, 1'b0);
            send_vertex(COORD_MIN, COORD_MAX, 1'b1);
            send_vertex(coord_t'(-1), '0, 1'b0);
            send_vertex(coord_t'(-1), '0, 1'b1);
        end
    endtask

    task automatic test_extremes();
        begin
            send_vertex(COORD_MIN, COORD_MIN, 1'b0);
            send_vertex(COORD_MAX, COORD_MAX, 1'b0);
            send_vertex(COORD_MIN, COORD_MAX, 1'b0);
            send_vertex(COORD_MAX, COORD_MIN, 1'b1);
            send_vertex(COORD_MAX, COORD_MAX, 1'b0);
            send_vertex(COORD_MAX, COORD_MAX - coord_t'(1), 1'b1);
        end
    endtask

    // one-LSB segments put the centroid exactly on a half step
    task automatic test_rounding_ties();
        begin
            send_vertex('0, '0, 1'b0);
            send_vertex(coord_t'(1), '0, 1'b1);
            send_vertex('0, '0, 1'b0);
            send_vertex(coord_t'(-1), coord_t'(-1), 1'b1);
            send_vertex(coord_t'(5), coord_t'(-3), 1'b0);
            send_vertex(coord_t'(6), coord_t'(-3), 1'b1);
        end
    endtask

    task automatic test_vertex_limit();
        int k;
        begin
            for (k = 0; k < MAX_POINTS + 8; k++)
                send_vertex(coord_t'($urandom), coord_t'($urandom), k == MAX_POINTS + 7);
        end
    endtask

    task automatic test_random_phase(input int items, input int send_pct, input int recv_pct);
        int start_count;
        begin
            send_idle_pct  = send_pct;
            recv_stall_pct = recv_pct;
            start_count    = sent_count;
            while (sent_count - start_count < items)
                send_random_polyline();
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (log_wr == log_rd)
            begin
                report_mismatch($sformatf("unexpected beat data=%h flag=%b",
                                          m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                want_centroid = centroid_log[log_rd];
                log_rd++;
                if (m_axis_tdata[23:0] !== want_centroid.center_x)
                    report_mismatch($sformatf("center_x %h, want %h",
                                              m_axis_tdata[23:0], want_centroid.center_x));
                if (m_axis_tdata[47:24] !== want_centroid.center_y)
                    report_mismatch($sformatf("center_y %h, want %h",
                                              m_axis_tdata[47:24], want_centroid.center_y));
                if (m_axis_tuser !== want_centroid.fell_back_first)
                    report_mismatch($sformatf("fell_back_first %b, want %b",
                                              m_axis_tuser, want_centroid.fell_back_first));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("polyline_length_weighted_centroid_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b1;
        mismatches     = 0;
        sent_count     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        log_wr         = 0;
        log_rd         = 0;
        clear_polyline();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_vertex();
        test_no_length();
        test_extremes();
        test_rounding_ties();
        test_vertex_limit();
        test_random_phase(RANDOM_ITEMS / 4, 0, 0);
        test_random_phase(RANDOM_ITEMS / 4, 76, 0);
        test_random_phase(RANDOM_ITEMS / 4, 0, 76);
        test_random_phase(RANDOM_ITEMS / 4, 38, 38);

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (log_wr != log_rd)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && log_wr == log_rd)
            $display("polyline_length_weighted_centroid_unit: match");
        else
            $display("polyline_length_weighted_centroid_unit: mismatch");
        $finish;
    end
endmodule
